/* hdl/tfb_pkg.sv */
// Shared types, codes and result decode for the transmit frame builder.
package tfb_pkg;

  typedef enum logic [2:0] {
    KIND_ID      = 3'd0,
    KIND_LEN_LO  = 3'd1,
    KIND_LEN_HI  = 3'd2,
    KIND_PAYLOAD = 3'd3,
    KIND_CHECK   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ITEM_START      = 3'd0,
    ITEM_START_ZERO = 3'd1,
    ITEM_PAY        = 3'd2,
    ITEM_PAY_LAST   = 3'd3,
    ITEM_REJECT     = 3'd4
  } item_t;

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_PAYLOAD = 1'b1;

  typedef struct packed {
    item_t      code;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } desc_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       done;
    logic       rej;
    logic       last;
  } res_t;

  function automatic res_t result_of(desc_t d, logic [1:0] idx);
    res_t r;
    r = '{data: 8'd0, kind: KIND_ID, done: 1'b0, rej: 1'b0, last: 1'b0};
    case (d.code)
      ITEM_START, ITEM_START_ZERO: begin
        case (idx)
          2'd0: begin
            r.data = d.b0;
            r.kind = KIND_ID;
          end
          2'd1: begin
            r.data = d.b1;
            r.kind = KIND_LEN_LO;
          end
          2'd2: begin
            r.data = d.b2;
            r.kind = KIND_LEN_HI;
            r.last = (d.code == ITEM_START);
          end
          default: begin
            r.data = 8'd0;
            r.kind = KIND_CHECK;
            r.done = 1'b1;
            r.last = 1'b1;
          end
        endcase
      end
      ITEM_PAY: begin
        r.data = d.b0;
        r.kind = KIND_PAYLOAD;
        r.last = 1'b1;
      end
      ITEM_PAY_LAST: begin
        if (idx == 2'd0) begin
          r.data = d.b0;
          r.kind = KIND_PAYLOAD;
        end else begin
          r.data = d.b1;
          r.kind = KIND_CHECK;
          r.done = 1'b1;
          r.last = 1'b1;
        end
      end
      default: begin
        r.rej  = 1'b1;
        r.last = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

/* hdl/tfb_seq.sv */
// Result sequencer: holds one item descriptor and emits its beats through an output register.
module tfb_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               desc_valid,
  output logic               desc_ready,
  input  tfb_pkg::desc_t     desc,
  output logic               res_valid,
  input  logic               res_stall,
  output tfb_pkg::res_t      res
);

  logic             item_v_r, item_v_nxt;
  tfb_pkg::desc_t   desc_r;
  logic [1:0]       idx_r, idx_nxt;
  logic             o_v_r, o_v_nxt;
  tfb_pkg::res_t    o_res_r;
  tfb_pkg::res_t    cur;
  logic             load;
  logic             take;

  always_comb begin
    cur        = tfb_pkg::result_of(desc_r, idx_r);
    load       = item_v_r && (!o_v_r || !res_stall);
    desc_ready = !item_v_r || (load && cur.last);
    take       = desc_valid && desc_ready;

    item_v_nxt = item_v_r;
    idx_nxt    = idx_r;
    if (load) begin
      if (cur.last) begin
        item_v_nxt = 1'b0;
        idx_nxt    = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
    if (take) begin
      item_v_nxt = 1'b1;
      idx_nxt    = 2'd0;
    end

    if (load) begin
      o_v_nxt = 1'b1;
    end else if (!res_stall) begin
      o_v_nxt = 1'b0;
    end else begin
      o_v_nxt = o_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      idx_r    <= 2'd0;
      o_v_r    <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
      idx_r    <= idx_nxt;
      o_v_r    <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      desc_r <= desc;
    end
    if (load) begin
      o_res_r <= cur;
    end
  end

  assign res_valid = o_v_r;
  assign res       = o_res_r;

endmodule

/* hdl/tx_frame_builder_sum_checksum_top.sv */
// Top level of the length-prefixed transmit frame builder with 8-bit sum checksum.
//
// Each accepted input item produces one to four output beats, one beat per cycle while
// out_stall is low: a payload item gives one beat (two on the last byte of a frame,
// payload then checksum), a start item gives three (four for a zero length), a refused
// item gives one. Frame state is updated in the cycle the item is accepted; the item is
// then held in a one-entry descriptor register that feeds an output register. The next
// item is accepted in the same cycle as the final beat of the held item moves into the
// output register, so payload bytes stream at one item per cycle and the output
// register pacing sets the rate for header beats.
module tx_frame_builder_sum_checksum_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [15:0] in_frame_length,
  input  logic [7:0]  in_payload_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [2:0]  out_byte_kind,
  output logic        out_frame_done,
  output logic        out_rejected,
  output logic        out_last_of_run
);

  logic [7:0]     frame_id_q_r;
  logic           busy_r, busy_nxt;
  logic [15:0]    left_r, left_nxt;
  logic [7:0]     sum_r, sum_nxt;
  logic [15:0]    left_dec;
  logic [7:0]     sum_add;
  logic           accept;
  logic           desc_ready;
  tfb_pkg::desc_t desc;
  tfb_pkg::res_t  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_id_q_r <= 8'd0;
    end else if (cfg_wr_en) begin
      frame_id_q_r <= cfg_wr_data;
    end
  end

  assign in_stall = !desc_ready;
  assign accept   = in_valid && desc_ready;

  always_comb begin
    sum_add  = sum_r + in_payload_byte;
    left_dec = (left_r != 16'd0) ? (left_r - 16'd1) : 16'd0;

    busy_nxt = busy_r;
    left_nxt = left_r;
    sum_nxt  = sum_r;
    desc     = '{code: tfb_pkg::ITEM_REJECT, b0: 8'd0, b1: 8'd0, b2: 8'd0};

    if (in_func == tfb_pkg::FUNC_START) begin
      if (!busy_r) begin
        sum_nxt  = 8'd0;
        left_nxt = in_frame_length;
        busy_nxt = (in_frame_length != 16'd0);
        desc.code = (in_frame_length == 16'd0) ? tfb_pkg::ITEM_START_ZERO
                                               : tfb_pkg::ITEM_START;
        desc.b0 = frame_id_q_r;
        desc.b1 = in_frame_length[7:0];
        desc.b2 = in_frame_length[15:8];
      end
    end else begin
      if (busy_r) begin
        sum_nxt  = sum_add;
        left_nxt = left_dec;
        busy_nxt = (left_dec != 16'd0);
        desc.code = (left_dec == 16'd0) ? tfb_pkg::ITEM_PAY_LAST : tfb_pkg::ITEM_PAY;
        desc.b0 = in_payload_byte;
        desc.b1 = sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      left_r <= 16'd0;
      sum_r  <= 8'd0;
    end else if (accept) begin
      busy_r <= busy_nxt;
      left_r <= left_nxt;
      sum_r  <= sum_nxt;
    end
  end

  tfb_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_valid (in_valid),
    .desc_ready (desc_ready),
    .desc       (desc),
    .res_valid  (out_valid),
    .res_stall  (out_stall),
    .res        (res)
  );

  assign out_byte        = res.data;
  assign out_byte_kind   = res.kind;
  assign out_frame_done  = res.done;
  assign out_rejected    = res.rej;
  assign out_last_of_run = res.last;

  a_idle_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (left_r != 16'd0))
    else $error("busy flag disagrees with remaining byte count");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_last_of_run && !out_rejected)
    else $error("checksum beat not marked as final beat of its item");

  a_check_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte_kind == tfb_pkg::KIND_CHECK) |-> out_frame_done)
    else $error("checksum beat without frame_done");

  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall && !out_last_of_run |-> in_stall)
    else $error("input taken while current item still has beats queued");

endmodule

/* bench/tx_frame_builder_sum_checksum_top_tb.sv */
// Self-checking bench for the transmit frame builder: predicts the frame bytes and checks each beat.
module tx_frame_builder_sum_checksum_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT       = 1000;
  localparam int HOLD_OFF_AT_BEAT = 150;
  localparam int HOLD_OFF_CYCLES  = 120;
  localparam int DRAIN_CYCLES     = 10;
  localparam int REPORT_LIMIT     = 10;

  class frame_checker;
    logic [7:0]      frame_id;
    logic            busy;
    logic [15:0]     bytes_left;
    logic [7:0]      running_sum;
    tfb_pkg::res_t   pending_beats[$];
    int              mismatches;

    function new();
      frame_id    = 8'd0;
      busy        = 1'b0;
      bytes_left  = 16'd0;
      running_sum = 8'd0;
      mismatches  = 0;
    endfunction

    function void queue_beat(logic [7:0] data, tfb_pkg::kind_t kind, logic done, logic rej,
                             logic last);
      tfb_pkg::res_t r;
      r.data = data;
      r.kind = kind;
      r.done = done;
      r.rej  = rej;
      r.last = last;
      pending_beats.push_back(r);
    endfunction

    function void take_item(logic func, logic [15:0] len, logic [7:0] pb);
      if (func == tfb_pkg::FUNC_START) begin
        if (busy) begin
          queue_beat(8'd0, tfb_pkg::KIND_ID, 1'b0, 1'b1, 1'b1);
        end else begin
          running_sum = 8'd0;
          bytes_left  = len;
          queue_beat(frame_id, tfb_pkg::KIND_ID, 1'b0, 1'b0, 1'b0);
          queue_beat(len[7:0], tfb_pkg::KIND_LEN_LO, 1'b0, 1'b0, 1'b0);
          queue_beat(len[15:8], tfb_pkg::KIND_LEN_HI, 1'b0, 1'b0, len != 16'd0);
          if (len == 16'd0) begin
            queue_beat(8'd0, tfb_pkg::KIND_CHECK, 1'b1, 1'b0, 1'b1);
          end else begin
            busy = 1'b1;
          end
        end
      end else if (!busy) begin
        queue_beat(8'd0, tfb_pkg::KIND_ID, 1'b0, 1'b1, 1'b1);
      end else begin
        running_sum = running_sum + pb;
        if (bytes_left != 16'd0) bytes_left = bytes_left - 16'd1;
        if (bytes_left == 16'd0) begin
          queue_beat(pb, tfb_pkg::KIND_PAYLOAD, 1'b0, 1'b0, 1'b0);
          queue_beat(running_sum, tfb_pkg::KIND_CHECK, 1'b1, 1'b0, 1'b1);
          busy = 1'b0;
        end else begin
          queue_beat(pb, tfb_pkg::KIND_PAYLOAD, 1'b0, 1'b0, 1'b1);
        end
      end
    endfunction

    function void check_beat(tfb_pkg::res_t got);
      tfb_pkg::res_t want;
      if (pending_beats.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected beat: byte %h kind %0d done %b rej %b last %b",
                   got.data, got.kind, got.done, got.rej, got.last);
        mismatches++;
      end else begin
        want = pending_beats.pop_front();
        if (got.data !== want.data || got.kind !== want.kind || got.done !== want.done ||
            got.rej !== want.rej || got.last !== want.last) begin
          if (mismatches < REPORT_LIMIT)
            $display({"mismatch: got byte %h kind %0d done %b rej %b last %b, ",
                      "wanted byte %h kind %0d done %b rej %b last %b"},
                     got.data, got.kind, got.done, got.rej, got.last,
                     want.data, want.kind, want.done, want.rej, want.last);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        cfg_wr_en       = 1'b0;
  logic [7:0]  cfg_wr_data     = 8'd0;
  logic        in_valid        = 1'b0;
  logic        in_func         = tfb_pkg::FUNC_START;
  logic [15:0] in_frame_length = 16'd0;
  logic [7:0]  in_payload_byte = 8'd0;
  logic        out_stall       = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic [2:0]  out_byte_kind;
  logic        out_frame_done;
  logic        out_rejected;
  logic        out_last_of_run;

  frame_checker sb;
  int idle_cycles   = 0;
  int beats_seen    = 0;
  int send_gap_max  = 3;
  int recv_gap_max  = 3;

  always #5 clk = ~clk;

  tx_frame_builder_sum_checksum_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_frame_length (in_frame_length),
    .in_payload_byte (in_payload_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_kind   (out_byte_kind),
    .out_frame_done  (out_frame_done),
    .out_rejected    (out_rejected),
    .out_last_of_run (out_last_of_run)
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tx_frame_builder_sum_checksum_top_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(input logic func, input logic [15:0] len, input logic [7:0] pb);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= func;
    in_frame_length <= len;
    in_payload_byte <= pb;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.take_item(func, len, pb);
  endtask

  task automatic take_beats();
    tfb_pkg::res_t got;
    int            gap;
    forever begin
      gap = $urandom_range(0, recv_gap_max);
      if (beats_seen == HOLD_OFF_AT_BEAT) gap = HOLD_OFF_CYCLES;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      got.data = out_byte;
      got.kind = tfb_pkg::kind_t'(out_byte_kind);
      got.done = out_frame_done;
      got.rej  = out_rejected;
      got.last = out_last_of_run;
      sb.check_beat(got);
      beats_seen++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
  endtask

  task automatic write_frame_id(input logic [7:0] id);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= id;
    @(posedge clk);
    sb.frame_id = id;
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly whole frames, with stray payloads, starts mid-frame and cut-short frames.
  task automatic run_frames(input int n_items);
    int          sent;
    int          pick;
    logic [15:0] len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(tfb_pkg::FUNC_PAYLOAD, 16'($urandom), 8'($urandom));
        sent++;
      end
      pick = $urandom_range(0, 9);
      if (pick < 2) len = 16'd0;
      else if (pick < 8) len = 16'($urandom_range(1, 6));
      else len = 16'($urandom_range(7, 40));
      send_item(tfb_pkg::FUNC_START, len, 8'($urandom));
      sent++;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_item(tfb_pkg::FUNC_START, 16'($urandom), 8'($urandom));
          sent++;
        end
        if ($urandom_range(0, 29) == 0) break;
        send_item(tfb_pkg::FUNC_PAYLOAD, 16'($urandom), 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    fork
      take_beats();
    join_none

    // Reset identifier, refusals, zero length and checksum wrap.
    send_item(tfb_pkg::FUNC_PAYLOAD, 16'hFFFF, 8'hFF);
    send_item(tfb_pkg::FUNC_START, 16'h0000, 8'hFF);
    send_item(tfb_pkg::FUNC_START, 16'h0001, 8'h00);
    send_item(tfb_pkg::FUNC_PAYLOAD, 16'hFFFF, 8'h00);
    send_item(tfb_pkg::FUNC_START, 16'h0003, 8'hFF);
    send_item(tfb_pkg::FUNC_START, 16'hFFFF, 8'hFF);
    send_item(tfb_pkg::FUNC_PAYLOAD, 16'h0000, 8'hFF);
    send_item(tfb_pkg::FUNC_PAYLOAD, 16'hFFFF, 8'hFF);
    send_item(tfb_pkg::FUNC_PAYLOAD, 16'h0000, 8'h80);

    write_frame_id(8'hFF);
    send_item(tfb_pkg::FUNC_START, 16'h0002, 8'h00);
    send_item(tfb_pkg::FUNC_PAYLOAD, 16'h0000, 8'h01);
    send_item(tfb_pkg::FUNC_PAYLOAD, 16'hFFFF, 8'hFE);
    send_item(tfb_pkg::FUNC_PAYLOAD, 16'h0000, 8'h00);
    send_item(tfb_pkg::FUNC_START, 16'h0000, 8'h00);

    write_frame_id(8'h00);
    run_frames(50);

    write_frame_id(8'($urandom));
    send_gap_max = 0;
    recv_gap_max = 0;
    run_frames(50);

    write_frame_id(8'hFF);
    send_gap_max = 3;
    recv_gap_max = 3;
    run_frames(50);

    write_frame_id(8'($urandom));
    run_frames(50);

    // Leave a maximum-length frame open at the end.
    write_frame_id(8'($urandom));
    send_item(tfb_pkg::FUNC_START, 16'hFFFF, 8'($urandom));
    repeat (8) send_item(tfb_pkg::FUNC_PAYLOAD, 16'($urandom), 8'($urandom));

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_beats.size() == 0) begin
      $display("tx_frame_builder_sum_checksum_top_tb: PASS");
    end else begin
      $display("tx_frame_builder_sum_checksum_top_tb: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/tfb_pkg.sv
hdl/tfb_seq.sv
hdl/tx_frame_builder_sum_checksum_top.sv
bench/tx_frame_builder_sum_checksum_top_tb.sv
